// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types of the disjunct code block.
package pdc_pkg;

   // Build-time sizing
   localparam int MAX_COEFFS = 63;
   localparam int ID_BITS    = 16;
   localparam int RADIX_BITS = 8;

   // Fixed port widths
   localparam int ELEMENT_ID_W = 16;
   localparam int RADIX_CSR_W  = 9;
   localparam int NUM_COEFFS_W = 6;
   localparam int POINT_W      = 6;
   localparam int BITPOS_W     = 14;
   localparam int CSR_DATA_W   = 9;
   localparam int CSR_INDEX_W  = 1;

   // Derived internal widths
   localparam int PT_BITS = $clog2(MAX_COEFFS + 1);
   localparam int DIG_AW  = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
   localparam int R_W     = RADIX_BITS + 1;
   localparam int HV_W    = RADIX_BITS + PT_BITS;
   localparam int DIV_W   = (ID_BITS > HV_W) ? ID_BITS : HV_W;
   localparam int SH_W    = $clog2(DIV_W);
   localparam int DSH_W   = DIV_W + R_W;
   localparam int BP_W    = PT_BITS + R_W;

   // Divider start positions: digit split and Horner reduction
   localparam logic [SH_W-1:0] DIG_SHIFT    = SH_W'(ID_BITS - 1);
   localparam logic [SH_W-1:0] HORNER_SHIFT = SH_W'(PT_BITS - 1);

   localparam logic [31:0] RADIX_TOP = 32'(1) << RADIX_BITS;

   // Register reset values
   localparam logic [RADIX_CSR_W-1:0]  RADIX_RESET      = RADIX_CSR_W'(16);
   localparam logic [NUM_COEFFS_W-1:0] NUM_COEFFS_RESET = NUM_COEFFS_W'(4);

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIX      = 1'b0,
      CSR_NUM_COEFFS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIG,
      ST_DIG_WAIT,
      ST_POINT,
      ST_READ,
      ST_MUL,
      ST_MOD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dig_zero;
      logic dig_start;
      logic dig_done;
      logic pt_init;
      logic rd_issue;
      logic h_start;
      logic h_done;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic y_zero;
      logic k_last;
      logic kk_one;
      logic j_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/pdc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pdc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 63,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pdc_divmod.sv =====
`timescale 1ns / 1ps
// Shift-subtract divider, one quotient bit per cycle from a chosen start position.
module pdc_divmod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pdc_pkg::DIV_W-1:0] dividend,
   input  logic [pdc_pkg::R_W-1:0]   divisor,
   input  logic [pdc_pkg::SH_W-1:0]  shift,
   output logic                      busy,
   output logic                      done,
   output logic [pdc_pkg::DIV_W-1:0] remainder,
   output logic [pdc_pkg::DIV_W-1:0] quotient
);
   import pdc_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [DSH_W-1:0] dsh;
   logic             fits;

   // Compare the running remainder against the divisor at the current bit
   assign dsh  = DSH_W'(divisor) << sh_ff;
   assign fits = DSH_W'(rem_ff) >= dsh;

   // Load on start, then advance one bit per cycle down to bit zero
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = dividend;
         quo_in  = '0;
         sh_in   = shift;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - DIV_W'(dsh);
         end
         quo_in = {quo_ff[DIV_W-2:0], fits};
         sh_in  = sh_ff - SH_W'(1);
         if (sh_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sh_ff  <= sh_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;
   assign quotient  = quo_ff;

endmodule

// ===== rtl/pdc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, digit split, Horner evaluation and result register.
module pdc_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [pdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pdc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [pdc_pkg::ELEMENT_ID_W-1:0] req_element_id,
   input  logic                             rsp_ready,
   input  pdc_pkg::cmd_type                 cmd,
   output pdc_pkg::status_type              status,
   output logic                             rsp_valid,
   output logic [pdc_pkg::POINT_W-1:0]      rsp_point_index,
   output logic [pdc_pkg::BITPOS_W-1:0]     rsp_bit_position,
   output logic                             rsp_last
);
   import pdc_pkg::*;

   // Configuration
   logic [RADIX_CSR_W-1:0]  radix_ff, radix_in;
   logic [NUM_COEFFS_W-1:0] num_coeffs_ff, num_coeffs_in;
   logic [31:0]             radix_wide;
   logic [R_W-1:0]          r_eff;
   logic [PT_BITS-1:0]      n_eff;

   // Per-word working state
   logic [R_W-1:0]        r_ff, r_in;
   logic [PT_BITS-1:0]    n_ff, n_in;
   logic [ID_BITS-1:0]    y_ff, y_in;
   logic [PT_BITS-1:0]    k_ff, k_in;
   logic [PT_BITS-1:0]    j_ff, j_in;
   logic [PT_BITS-1:0]    kk_ff, kk_in;
   logic [RADIX_BITS-1:0] acc_ff, acc_in;
   logic [PT_BITS-1:0]    kk_minus;

   // Result register
   logic                out_valid_ff, out_valid_in;
   logic [POINT_W-1:0]  point_ff, point_in;
   logic [BITPOS_W-1:0] bitpos_ff, bitpos_in;
   logic                last_ff, last_in;
   logic [BP_W-1:0]     bp_sum;

   // Divider and digit store hookup
   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [SH_W-1:0]       div_shift;
   logic                  div_busy;
   logic                  div_done;
   logic [DIV_W-1:0]      div_rem;
   logic [DIV_W-1:0]      div_quo;
   logic [HV_W-1:0]       hv;
   logic                  ram_wr_en;
   logic [DIG_AW-1:0]     ram_wr_addr;
   logic [RADIX_BITS-1:0] ram_wr_data;
   logic [DIG_AW-1:0]     ram_rd_addr;
   logic [RADIX_BITS-1:0] ram_rd_data;

   // Register writes
   always_comb begin
      radix_in      = radix_ff;
      num_coeffs_in = num_coeffs_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RADIX:      radix_in      = csr_wdata[RADIX_CSR_W-1:0];
            CSR_NUM_COEFFS: num_coeffs_in = csr_wdata[NUM_COEFFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         num_coeffs_ff <= NUM_COEFFS_RESET;
      end else begin
         radix_ff      <= radix_in;
         num_coeffs_ff <= num_coeffs_in;
      end
   end

   // Clamp radix into [2, 2^RADIX_BITS] and the coefficient count to the store depth
   always_comb begin
      radix_wide = 32'(radix_ff);
      if (radix_wide < 32'd2) begin
         r_eff = R_W'(2);
      end else if (radix_wide > RADIX_TOP) begin
         r_eff = R_W'(RADIX_TOP);
      end else begin
         r_eff = R_W'(radix_wide);
      end
      if (num_coeffs_ff > NUM_COEFFS_W'(MAX_COEFFS)) begin
         n_eff = PT_BITS'(MAX_COEFFS);
      end else begin
         n_eff = PT_BITS'(num_coeffs_ff);
      end
   end

   // Horner term: acc * j + next coefficient
   assign hv = HV_W'(acc_ff) * HV_W'(j_ff) + HV_W'(ram_rd_data);

   // Share the divider between digit split and Horner reduction
   assign div_start    = cmd.dig_start | cmd.h_start;
   assign div_dividend = cmd.h_start ? DIV_W'(hv) : DIV_W'(y_ff);
   assign div_shift    = cmd.h_start ? HORNER_SHIFT : DIG_SHIFT;

   pdc_divmod u_divmod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (r_ff),
      .shift     (div_shift),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem),
      .quotient  (div_quo)
   );

   // Digit store: written low digit first, read high digit first
   assign kk_minus    = kk_ff - PT_BITS'(1);
   assign ram_wr_en   = cmd.dig_zero | cmd.dig_done;
   assign ram_wr_addr = k_ff[DIG_AW-1:0];
   assign ram_wr_data = cmd.dig_zero ? '0 : div_rem[RADIX_BITS-1:0];
   assign ram_rd_addr = kk_minus[DIG_AW-1:0];

   pdc_ram #(
      .WIDTH (RADIX_BITS),
      .DEPTH (MAX_COEFFS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Working state updates
   always_comb begin
      r_in   = r_ff;
      n_in   = n_ff;
      y_in   = y_ff;
      k_in   = k_ff;
      j_in   = j_ff;
      kk_in  = kk_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         r_in = r_eff;
         n_in = n_eff;
         y_in = ID_BITS'(req_element_id);
         k_in = '0;
         j_in = '0;
      end
      if (cmd.dig_zero) begin
         k_in = k_ff + PT_BITS'(1);
      end
      if (cmd.dig_done) begin
         y_in = div_quo[ID_BITS-1:0];
         k_in = k_ff + PT_BITS'(1);
      end
      if (cmd.pt_init) begin
         acc_in = '0;
         kk_in  = n_ff;
      end
      if (cmd.h_done) begin
         acc_in = div_rem[RADIX_BITS-1:0];
         kk_in  = kk_minus;
      end
      if (cmd.emit) begin
         j_in = j_ff + PT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      n_ff   <= n_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= '0;
         j_ff  <= '0;
         kk_ff <= '0;
      end else begin
         k_ff  <= k_in;
         j_ff  <= j_in;
         kk_ff <= kk_in;
      end
   end

   // Result register: load on emit, drop when taken
   assign bp_sum = BP_W'(j_ff) * BP_W'(r_ff) + BP_W'(acc_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      point_in     = point_ff;
      bitpos_in    = bitpos_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         point_in     = POINT_W'(j_ff);
         bitpos_in    = BITPOS_W'(bp_sum);
         last_in      = (j_ff == n_ff);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff  <= point_in;
      bitpos_ff <= bitpos_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_point_index  = point_ff;
   assign rsp_bit_position = bitpos_ff;
   assign rsp_last         = last_ff;

   // Status back to the controller
   always_comb begin
      status          = '0;
      status.n_zero   = (n_ff == '0);
      status.y_zero   = (y_ff == '0);
      status.k_last   = (k_ff == (n_ff - PT_BITS'(1)));
      status.kk_one   = (kk_ff == PT_BITS'(1));
      status.j_last   = (j_ff == n_ff);
      status.div_done = div_done;
      status.out_free = !out_valid_ff || rsp_ready;
   end

   // Divider is never restarted mid-operation
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // Every finished reduction leaves a remainder below the radix
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_rem < DIV_W'(r_ff)))
      else $error("divider remainder not below radix");

   // Stored digits are always valid base-radix digits
   a_digit_below_radix: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (R_W'(ram_wr_data) < r_ff))
      else $error("digit written out of range");

   // A new result only overwrites a free or departing result word
   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

endmodule

// ===== rtl/pdc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing digit split, Horner steps and result emission.
module pdc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pdc_pkg::status_type status,
   output pdc_pkg::cmd_type    cmd
);
   import pdc_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIG;
         end
         ST_DIG: begin
            if (status.n_zero) begin
               state_in = ST_POINT;
            end else if (status.y_zero) begin
               state_in = status.k_last ? ST_POINT : ST_DIG;
            end else begin
               state_in = ST_DIG_WAIT;
            end
         end
         ST_DIG_WAIT: begin
            if (status.div_done) state_in = status.k_last ? ST_POINT : ST_DIG;
         end
         ST_POINT: begin
            state_in = status.n_zero ? ST_EMIT : ST_READ;
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (status.div_done) state_in = status.kk_one ? ST_EMIT : ST_READ;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = status.j_last ? ST_IDLE : ST_POINT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIG: begin
            if (!status.n_zero) begin
               if (status.y_zero) begin
                  cmd.dig_zero = 1'b1;
               end else begin
                  cmd.dig_start = 1'b1;
               end
            end
         end
         ST_DIG_WAIT: cmd.dig_done = status.div_done;
         ST_POINT:    cmd.pt_init  = 1'b1;
         ST_READ:     cmd.rd_issue = 1'b1;
         ST_MUL:      cmd.h_start  = 1'b1;
         ST_MOD:      cmd.h_done   = status.div_done;
         ST_EMIT:     cmd.emit     = status.out_free;
         default: ;
      endcase
   end

endmodule

// ===== rtl/polynomial_disjunct_code_positions_core.sv =====
`timescale 1ns / 1ps
// Top level of the polynomial disjunct code bit position generator.
//
// Usage:
//   req_*  : one element id word per handshake; ready is high only when idle.
//   rsp_*  : num_coeffs+1 result words per id, one per evaluation point j,
//            with bit_position = j*radix + p(j) mod radix and last on j = num_coeffs.
//   csr_*  : index 0 writes radix, index 1 writes num_coeffs; always ready.
//            Write only while no id is in flight.
// Steps, with n = num_coeffs (clamped) and one shared 1-bit-per-cycle divider:
//   digit split : n digits, each written directly as zero once the remaining id is zero,
//                 otherwise taken as the remainder of dividing the id by radix.
//   per point   : n Horner steps (Horner step = RAM read, multiply-add,
//                 reduction mod radix).
// The next id is taken in the cycle after the last result is loaded into the output
// register, even if that result is still waiting to be taken.
// Reset sets radix to 16 and num_coeffs to 4 and returns to idle; a stalled receiver
// holds the output register and pauses the block before the next point is loaded.
module polynomial_disjunct_code_positions_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pdc_pkg::ELEMENT_ID_W-1:0] req_element_id,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pdc_pkg::POINT_W-1:0]      rsp_point_index,
   output logic [pdc_pkg::BITPOS_W-1:0]     rsp_bit_position,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pdc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes never stall
   assign csr_ready = 1'b1;

   pdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_element_id   (req_element_id),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_point_index  (rsp_point_index),
      .rsp_bit_position (rsp_bit_position),
      .rsp_last         (rsp_last)
   );

endmodule
